// File: design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and table builders for the stepper coil sequencer.
// ----------------------------------------------------------------------------
package scp_pkg;

    // Substeps per full step, clamped to the supported range
    localparam int MICRO_PER_STEP = 16;
    localparam int MPS_EFF = (MICRO_PER_STEP < 8) ? 8 :
                             ((MICRO_PER_STEP > 16) ? 16 : MICRO_PER_STEP);

    localparam int POS_W     = 6;
    localparam int MOD_W     = POS_W + 1;
    localparam int SUB_W     = $clog2(MPS_EFF + 1);
    localparam int DUTY_W    = 12;
    localparam int PAT_W     = 4;
    localparam int CURVE_W   = 8;
    localparam int FULL_DUTY = 255;

    localparam logic [MOD_W-1:0] MOD_MICRO = MOD_W'(4 * MPS_EFF);
    localparam logic [MOD_W-1:0] MOD_HALF  = MOD_W'(8);
    localparam logic [MOD_W-1:0] MOD_FULL  = MOD_W'(4);

    // Phase boundaries within the microstep cycle
    localparam logic [POS_W-1:0] PHASE1_BASE = POS_W'(MPS_EFF);
    localparam logic [POS_W-1:0] PHASE2_BASE = POS_W'(2 * MPS_EFF);
    localparam logic [POS_W-1:0] PHASE3_BASE = POS_W'(3 * MPS_EFF);

    localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(FULL_DUTY * 16);

    typedef enum logic [1:0] {
        MODE_SINGLE = 2'd0,
        MODE_DOUBLE = 2'd1,
        MODE_HALF   = 2'd2,
        MODE_MICRO  = 2'd3
    } mode_t;

    localparam logic FUNC_STEP    = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [PAT_W-1:0]  pat;
    } drive_t;

    typedef logic [MPS_EFF:0][CURVE_W-1:0] curve_tab_t;

    function automatic logic [CURVE_W-1:0] curve16(input int i);
        logic [CURVE_W-1:0] v;
        case (i)
            0:       v = 8'd0;
            1:       v = 8'd25;
            2:       v = 8'd50;
            3:       v = 8'd74;
            4:       v = 8'd98;
            5:       v = 8'd120;
            6:       v = 8'd141;
            7:       v = 8'd162;
            8:       v = 8'd180;
            9:       v = 8'd197;
            10:      v = 8'd212;
            11:      v = 8'd225;
            12:      v = 8'd236;
            13:      v = 8'd244;
            14:      v = 8'd250;
            15:      v = 8'd253;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    function automatic logic [CURVE_W-1:0] curve8(input int i);
        logic [CURVE_W-1:0] v;
        case (i)
            0:       v = 8'd0;
            1:       v = 8'd50;
            2:       v = 8'd98;
            3:       v = 8'd142;
            4:       v = 8'd180;
            5:       v = 8'd212;
            6:       v = 8'd236;
            7:       v = 8'd250;
            default: v = 8'd255;
        endcase
        return v;
    endfunction

    // Quarter-wave table resampled to MPS_EFF+1 points, built at elaboration
    function automatic curve_tab_t build_curve();
        curve_tab_t t;
        int         k;
        for (k = 0; k <= MPS_EFF; k++)
        begin
            if (MPS_EFF == 8)
                t[k] = curve8(k);
            else
                t[k] = curve16((16 * k + MPS_EFF / 2) / MPS_EFF);
        end
        return t;
    endfunction

    localparam curve_tab_t CURVE_TAB = build_curve();

    function automatic logic [PAT_W-1:0] full_pat(input logic [1:0] idx);
        logic [PAT_W-1:0] p;
        case (idx)
            2'd0:    p = 4'h3;
            2'd1:    p = 4'h6;
            2'd2:    p = 4'hC;
            default: p = 4'h9;
        endcase
        return p;
    endfunction

    function automatic logic [PAT_W-1:0] half_pat(input logic [2:0] idx);
        logic [PAT_W-1:0] p;
        case (idx)
            3'd0:    p = 4'h1;
            3'd1:    p = 4'h3;
            3'd2:    p = 4'h2;
            3'd3:    p = 4'h6;
            3'd4:    p = 4'h4;
            3'd5:    p = 4'hC;
            3'd6:    p = 4'h8;
            default: p = 4'h9;
        endcase
        return p;
    endfunction

endpackage

// File: design/stepper_coil_sequencer_unit.sv
// ----------------------------------------------------------------------------
// stepper_coil_sequencer_unit
// Step/release command in, coil pattern, PWM duties and position out.
// ----------------------------------------------------------------------------
//   channel  | signals                                   | flow
//   ---------+-------------------------------------------+---------
//   in       | in_valid, in_stall, func, backward        | to block
//   out      | out_valid, out_stall, duty_a, duty_b,     | from block
//            | pin_a1, pin_a2, pin_b1, pin_b2, position  |
//   cfg      | cfg_wr_en, cfg_wr_data (step_mode)        | to block
//
// One transaction per cycle while out_stall is low; a command passes the command
// register, then the result register, with the position update and table
// lookup between them. Reset clears mode, position and both valid flags.
// A stalled result holds in the output register while one more command
// waits in the command register; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module stepper_coil_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic                           backward,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [scp_pkg::DUTY_W-1:0]     duty_a,
    output logic [scp_pkg::DUTY_W-1:0]     duty_b,
    output logic                           pin_a1,
    output logic                           pin_a2,
    output logic                           pin_b1,
    output logic                           pin_b2,
    output logic [scp_pkg::POS_W-1:0]      position,
    input  logic                           cfg_wr_en,
    input  logic [1:0]                     cfg_wr_data
);

    scp_pkg::mode_t             mode_reg;
    logic [scp_pkg::POS_W-1:0]  pos_reg;
    logic [scp_pkg::POS_W-1:0]  pos_next;
    logic                       cmd_valid_reg;
    logic                       cmd_valid_next;
    logic                       cmd_func_reg;
    logic                       cmd_back_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    scp_pkg::drive_t            drive_reg;
    scp_pkg::drive_t            drive_next;
    logic [scp_pkg::POS_W-1:0]  position_reg;
    logic [scp_pkg::POS_W-1:0]  position_next;
    logic [scp_pkg::POS_W-1:0]  pos_stepped;
    logic                       out_free;
    logic                       cmd_move;
    logic                       in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign cmd_move  = cmd_valid_reg && out_free;
    assign in_stall  = cmd_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    scp_position u_position (
        .mode     (mode_reg),
        .pos_cur  (pos_reg),
        .backward (cmd_back_reg),
        .pos_next (pos_stepped)
    );

    // release keeps the position
    assign position_next = (cmd_func_reg == scp_pkg::FUNC_RELEASE) ? pos_reg : pos_stepped;
    assign pos_next      = cmd_move ? position_next : pos_reg;

    scp_drive u_drive (
        .mode        (mode_reg),
        .release_all (cmd_func_reg == scp_pkg::FUNC_RELEASE),
        .pos         (position_next),
        .drive       (drive_next)
    );

    always_comb
    begin
        if (in_accept)
            cmd_valid_next = 1'b1;
        else if (out_free)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;

        if (cmd_move)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= scp_pkg::MODE_SINGLE;
            pos_reg       <= '0;
            cmd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= scp_pkg::mode_t'(cfg_wr_data);
            pos_reg       <= pos_next;
            cmd_valid_reg <= cmd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_func_reg <= func;
            cmd_back_reg <= backward;
        end
        if (cmd_move)
        begin
            drive_reg    <= drive_next;
            position_reg <= position_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign duty_a    = drive_reg.duty_a;
    assign duty_b    = drive_reg.duty_b;
    assign pin_a2    = drive_reg.pat[0];
    assign pin_b1    = drive_reg.pat[1];
    assign pin_a1    = drive_reg.pat[2];
    assign pin_b2    = drive_reg.pat[3];
    assign position  = position_reg;

`ifndef SYNTHESIS
    // a new result appears only when a held command moved forward
    assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || !out_stall) && !cmd_valid_reg |=> !out_valid_reg)
        else $error("result valid without a command");

    // a release leaves the position where it was
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_move && (cmd_func_reg == scp_pkg::FUNC_RELEASE)
        |=> (position_reg == $past(pos_reg)) && (pos_reg == $past(pos_reg)))
        else $error("release moved the position");

    // half-step positions stay within one eight-step cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_move && (cmd_func_reg == scp_pkg::FUNC_STEP)
        && (mode_reg == scp_pkg::MODE_HALF) && !cfg_wr_en
        |=> pos_reg < scp_pkg::POS_W'(8))
        else $error("half-step position out of range");

    // back pressure only when both stages hold a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> cmd_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with free space");
`endif

endmodule

// File: design/scp_position.sv
// ----------------------------------------------------------------------------
// scp_position
// Next step position: reduce to the mode's cycle, then move one place.
// ----------------------------------------------------------------------------
module scp_position (
    input  scp_pkg::mode_t                 mode,
    input  logic [scp_pkg::POS_W-1:0]      pos_cur,
    input  logic                           backward,
    output logic [scp_pkg::POS_W-1:0]      pos_next
);

    logic [scp_pkg::MOD_W-1:0] pos_ext;
    logic [scp_pkg::MOD_W-1:0] mod_len;
    logic [scp_pkg::MOD_W-1:0] pos_red;
    logic [scp_pkg::MOD_W-1:0] pos_new;

    assign pos_ext = {1'b0, pos_cur};

    always_comb
    begin
        unique case (mode)
            scp_pkg::MODE_MICRO:
            begin
                mod_len = scp_pkg::MOD_MICRO;
                // position is below twice the cycle length
                pos_red = (pos_ext >= scp_pkg::MOD_MICRO) ?
                          (pos_ext - scp_pkg::MOD_MICRO) : pos_ext;
            end
            scp_pkg::MODE_HALF:
            begin
                mod_len = scp_pkg::MOD_HALF;
                pos_red = pos_ext & (scp_pkg::MOD_HALF - 1'b1);
            end
            default:
            begin
                mod_len = scp_pkg::MOD_FULL;
                pos_red = pos_ext & (scp_pkg::MOD_FULL - 1'b1);
            end
        endcase
    end

    always_comb
    begin
        if (backward)
            pos_new = (pos_red == '0) ? (mod_len - 1'b1) : (pos_red - 1'b1);
        else
            pos_new = (pos_red == mod_len - 1'b1) ? '0 : (pos_red + 1'b1);
    end

    assign pos_next = pos_new[scp_pkg::POS_W-1:0];

endmodule

// File: design/scp_drive.sv
// ----------------------------------------------------------------------------
// scp_drive
// Coil pattern and PWM duties for a given position and mode.
// ----------------------------------------------------------------------------
module scp_drive (
    input  scp_pkg::mode_t                 mode,
    input  logic                           release_all,
    input  logic [scp_pkg::POS_W-1:0]      pos,
    output scp_pkg::drive_t                drive
);

    logic [1:0]                phase;
    logic [scp_pkg::POS_W-1:0] phase_base;
    logic [scp_pkg::POS_W-1:0] sub_full;
    logic [scp_pkg::SUB_W-1:0] sub;
    logic [scp_pkg::SUB_W-1:0] sub_inv;
    logic [scp_pkg::SUB_W-1:0] k_a;
    logic [scp_pkg::SUB_W-1:0] k_b;

    // phase = pos / MPS_EFF by range compare
    always_comb
    begin
        if (pos >= scp_pkg::PHASE3_BASE)
        begin
            phase      = 2'd3;
            phase_base = scp_pkg::PHASE3_BASE;
        end
        else if (pos >= scp_pkg::PHASE2_BASE)
        begin
            phase      = 2'd2;
            phase_base = scp_pkg::PHASE2_BASE;
        end
        else if (pos >= scp_pkg::PHASE1_BASE)
        begin
            phase      = 2'd1;
            phase_base = scp_pkg::PHASE1_BASE;
        end
        else
        begin
            phase      = 2'd0;
            phase_base = '0;
        end
    end

    assign sub_full = pos - phase_base;
    assign sub      = sub_full[scp_pkg::SUB_W-1:0];
    assign sub_inv  = scp_pkg::SUB_W'(scp_pkg::MPS_EFF) - sub;
    assign k_a      = phase[0] ? sub : sub_inv;
    assign k_b      = phase[0] ? sub_inv : sub;

    always_comb
    begin
        if (release_all)
        begin
            drive.duty_a = '0;
            drive.duty_b = '0;
            drive.pat    = '0;
        end
        else
        begin
            unique case (mode)
                scp_pkg::MODE_MICRO:
                begin
                    drive.duty_a = {scp_pkg::CURVE_TAB[k_a], 4'b0000};
                    drive.duty_b = {scp_pkg::CURVE_TAB[k_b], 4'b0000};
                    drive.pat    = scp_pkg::full_pat(phase);
                end
                scp_pkg::MODE_HALF:
                begin
                    drive.duty_a = scp_pkg::DUTY_FULL;
                    drive.duty_b = scp_pkg::DUTY_FULL;
                    drive.pat    = scp_pkg::half_pat(pos[2:0]);
                end
                default:
                begin
                    drive.duty_a = scp_pkg::DUTY_FULL;
                    drive.duty_b = scp_pkg::DUTY_FULL;
                    drive.pat    = scp_pkg::full_pat(pos[1:0]);
                end
            endcase
        end
    end

endmodule

// File: test/tb_stepper_coil_sequencer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_coil_sequencer_unit
// Drives step and release commands through every step mode and checks the
// coil pins, PWM duties and position of each result against an in-bench
// predictor. Both sides idle at random, and one long output hold-off fills
// the pipeline so that the block must stall its command input.
// ----------------------------------------------------------------------------
module tb_stepper_coil_sequencer_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    // Quarter-wave tables and coil sequences, entry 0 in the low bits
    localparam logic [17*8-1:0] SINE16 = {8'd255, 8'd253, 8'd250, 8'd244, 8'd236, 8'd225,
                                          8'd212, 8'd197, 8'd180, 8'd162, 8'd141, 8'd120,
                                          8'd98, 8'd74, 8'd50, 8'd25, 8'd0};
    localparam logic [9*8-1:0]  SINE8  = {8'd255, 8'd250, 8'd236, 8'd212, 8'd180, 8'd142,
                                          8'd98, 8'd50, 8'd0};
    localparam logic [15:0]     FULL_SEQ = 16'h9C63;
    localparam logic [31:0]     HALF_SEQ = 32'h98C46231;

    typedef struct {
        logic [scp_pkg::DUTY_W-1:0] duty_a;
        logic [scp_pkg::DUTY_W-1:0] duty_b;
        logic                       a1;
        logic                       a2;
        logic                       b1;
        logic                       b2;
        logic [scp_pkg::POS_W-1:0]  position;
    } coil_drive_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_stall;
    logic                       func        = scp_pkg::FUNC_STEP;
    logic                       backward    = 1'b0;
    logic                       out_valid;
    logic                       out_stall   = 1'b0;
    logic [scp_pkg::DUTY_W-1:0] duty_a;
    logic [scp_pkg::DUTY_W-1:0] duty_b;
    logic                       pin_a1;
    logic                       pin_a2;
    logic                       pin_b1;
    logic                       pin_b2;
    logic [scp_pkg::POS_W-1:0]  position;
    logic                       cfg_wr_en   = 1'b0;
    logic [1:0]                 cfg_wr_data = 2'd0;

    // Predictor state
    scp_pkg::mode_t             cur_mode = scp_pkg::MODE_SINGLE;
    logic [scp_pkg::POS_W-1:0]  cur_pos  = '0;
    coil_drive_t                expected_drive[$];

    int                err_count = 0;
    int                cycle_cnt = 0;
    bit                tx_idle   = 1'b1;
    bit                rx_idle   = 1'b1;
    int                hold_asks = 0;
    int                hold_done = 0;
    int                hold_left = 0;
    int                rx_wait   = 0;
    int unsigned       rx_draw;
    coil_drive_t       chk_want;

    stepper_coil_sequencer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .backward    (backward),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .pin_a1      (pin_a1),
        .pin_a2      (pin_a2),
        .pin_b1      (pin_b1),
        .pin_b2      (pin_b2),
        .position    (position),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic int sine_at(input int k);
        int m = scp_pkg::MPS_EFF;
        if (k > m)
            k = m;
        if (m == 8)
            return int'(SINE8[8*k +: 8]);
        return int'(SINE16[8*((16 * k + m / 2) / m) +: 8]);
    endfunction

    function automatic coil_drive_t advance_coils(input logic f, input logic b);
        coil_drive_t d;
        int          cyc;
        int          p;
        int          ph;
        int          sub;
        int          da;
        int          db;
        logic [3:0]  pat;
        da  = 0;
        db  = 0;
        pat = 4'h0;
        if (f == scp_pkg::FUNC_STEP)
        begin
            case (cur_mode)
                scp_pkg::MODE_MICRO: cyc = 4 * scp_pkg::MPS_EFF;
                scp_pkg::MODE_HALF:  cyc = 8;
                default:             cyc = 4;
            endcase
            // a mode change folds a large position into the new cycle first
            p = int'(cur_pos) % cyc;
            p = b ? (p + cyc - 1) % cyc : (p + 1) % cyc;
            cur_pos = scp_pkg::POS_W'(p);
            da = scp_pkg::FULL_DUTY;
            db = scp_pkg::FULL_DUTY;
            if (cur_mode == scp_pkg::MODE_MICRO)
            begin
                ph  = (p / scp_pkg::MPS_EFF) % 4;
                sub = p % scp_pkg::MPS_EFF;
                if (ph % 2 == 0)
                begin
                    da = sine_at(scp_pkg::MPS_EFF - sub);
                    db = sine_at(sub);
                end
                else
                begin
                    da = sine_at(sub);
                    db = sine_at(scp_pkg::MPS_EFF - sub);
                end
                pat = FULL_SEQ[4*ph +: 4];
            end
            else if (cur_mode == scp_pkg::MODE_HALF)
                pat = HALF_SEQ[4*(p % 8) +: 4];
            else
                pat = FULL_SEQ[4*(p % 4) +: 4];
            da = da * 16;
            db = db * 16;
        end
        d.duty_a   = scp_pkg::DUTY_W'(da);
        d.duty_b   = scp_pkg::DUTY_W'(db);
        d.a1       = pat[2];
        d.a2       = pat[0];
        d.b1       = pat[1];
        d.b2       = pat[3];
        d.position = cur_pos;
        return d;
    endfunction

    // ------------------------------------------------------------------------
    // Result side: stall driver and checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_done)
        begin
            hold_done <= hold_done + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (rx_wait != 0)
        begin
            out_stall <= 1'b1;
            rx_wait   <= rx_wait - 1;
        end
        else if (out_valid && !out_stall)
        begin
            rx_draw = rx_idle ? $urandom_range(0, 19) : 0;
            out_stall <= (rx_draw != 0);
            rx_wait   <= (rx_draw != 0) ? int'(rx_draw) - 1 : 0;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_drive.size() == 0)
                report_mismatch("result with none pending (position)", int'(position), -1);
            else
            begin
                chk_want = expected_drive.pop_front();
                if (duty_a !== chk_want.duty_a)
                    report_mismatch("duty_a", int'(duty_a), int'(chk_want.duty_a));
                if (duty_b !== chk_want.duty_b)
                    report_mismatch("duty_b", int'(duty_b), int'(chk_want.duty_b));
                if (pin_a1 !== chk_want.a1)
                    report_mismatch("pin_a1", int'(pin_a1), int'(chk_want.a1));
                if (pin_a2 !== chk_want.a2)
                    report_mismatch("pin_a2", int'(pin_a2), int'(chk_want.a2));
                if (pin_b1 !== chk_want.b1)
                    report_mismatch("pin_b1", int'(pin_b1), int'(chk_want.b1));
                if (pin_b2 !== chk_want.b2)
                    report_mismatch("pin_b2", int'(pin_b2), int'(chk_want.b2));
                if (position !== chk_want.position)
                    report_mismatch("position", int'(position), int'(chk_want.position));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------
    // Leaves in_valid high after the transaction; the next call with a gap, or settle, lowers it.
    task automatic send_cmd(input logic f, input logic b);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        backward <= b;
        do
            @(posedge clk);
        while (in_stall);
        expected_drive.push_back(advance_coils(f, b));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_mode(input scp_pkg::mode_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_mode = m;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset mode is single: wrap below zero, then a release
    task automatic test_single_after_reset();
        send_cmd(scp_pkg::FUNC_STEP, 1'b0);
        send_cmd(scp_pkg::FUNC_STEP, 1'b0);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_RELEASE, 1'b1);
        settle();
    endtask

    // Microstep wrap both ways through the top of the position range
    task automatic test_micro_wrap();
        int i;
        write_mode(scp_pkg::MODE_MICRO);
        send_cmd(scp_pkg::FUNC_RELEASE, 1'b0);
        for (i = 0; i < 4; i++)
            send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_STEP, 1'b0);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        settle();
    endtask

    // Switching modes while the position is beyond the new cycle length
    task automatic test_mode_change();
        write_mode(scp_pkg::MODE_HALF);
        send_cmd(scp_pkg::FUNC_STEP, 1'b0);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_RELEASE, 1'b0);
        settle();
        write_mode(scp_pkg::MODE_DOUBLE);
        send_cmd(scp_pkg::FUNC_STEP, 1'b1);
        send_cmd(scp_pkg::FUNC_STEP, 1'b0);
        settle();
    endtask

    // Receiver holds off long enough that the block backs up into in_stall
    task automatic test_output_hold();
        int i;
        tx_idle = 1'b0;
        @(negedge clk);
        hold_asks++;
        @(posedge clk);
        for (i = 0; i < 12; i++)
            send_cmd(scp_pkg::FUNC_STEP, 1'($urandom_range(0, 1)));
        settle();
        tx_idle = 1'b1;
    endtask

    // Random direction runs with releases, through every step mode
    task automatic test_random_walk();
        int   ph_i;
        int   i;
        logic dir;
        dir = 1'b0;
        for (ph_i = 0; ph_i < 10; ph_i++)
        begin
            case (ph_i)
                0:       write_mode(scp_pkg::MODE_MICRO);
                1:       write_mode(scp_pkg::MODE_SINGLE);
                2:       write_mode(scp_pkg::MODE_HALF);
                3:       write_mode(scp_pkg::MODE_DOUBLE);
                default: write_mode(scp_pkg::mode_t'($urandom_range(0, 3)));
            endcase
            tx_idle = (ph_i == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (ph_i == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (i = 0; i < 50; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    dir = ~dir;
                if ($urandom_range(0, 7) == 0)
                    send_cmd(scp_pkg::FUNC_RELEASE, 1'($urandom_range(0, 1)));
                else
                    send_cmd(scp_pkg::FUNC_STEP, dir);
            end
            settle();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_after_reset();
        test_micro_wrap();
        test_mode_change();
        test_output_hold();
        test_random_walk();
        settle();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: stepper_coil_sequencer_unit.f
design/scp_pkg.sv
design/scp_position.sv
design/scp_drive.sv
design/stepper_coil_sequencer_unit.sv
test/tb_stepper_coil_sequencer_unit.sv
